/* design/sddf_pkg.sv */
package sddf_pkg;

  // Field widths of the input word and of the result word.
  localparam int unsigned ValueW = 28;
  localparam int unsigned PosW   = 3;
  localparam int unsigned CodeW  = 4;

  // Default number of display positions.
  localparam int unsigned PositionsDefault = 8;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;

  // Display codes.
  localparam logic [CodeW-1:0] CodeZero  = 4'd0;
  localparam logic [CodeW-1:0] CodeMinus = 4'd10;
  localparam logic [CodeW-1:0] CodeBlank = 4'd11;
  localparam logic [CodeW-1:0] CodeTen   = 4'd10;

  // Division by ten as a multiplication by a scaled reciprocal.
  // The quotient floor(n * RecipMul / 2^RecipShift) is exact for all n below 2^32.
  localparam int unsigned     RecipW     = 32;
  localparam logic [RecipW-1:0] RecipMul = 32'hCCCC_CCCD;
  localparam int unsigned     RecipShift = 35;
  localparam int unsigned     ProdW      = ValueW + RecipW;
  localparam int unsigned     QuotW      = ProdW - RecipShift;

  // One queued word: magnitude of the value and its sign.
  typedef struct packed {
    logic [ValueW-1:0] mag;
    logic              neg;
  } item_t;

endpackage

/* design/sddf_front.sv */
module sddf_front (
  input  logic                         in_valid_i,
  input  logic [sddf_pkg::ValueW-1:0]  value_i,
  output logic                         in_stall_o,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output sddf_pkg::item_t              q_item_o
);
  import sddf_pkg::*;

  logic              neg;
  logic [ValueW-1:0] mag;

  // Split the two's complement word into sign and magnitude.
  // The most negative word maps to 2^27, which still fits in ValueW bits.
  assign neg = value_i[ValueW-1];
  assign mag = neg ? (ValueW'(0) - value_i) : value_i;

  // A word is taken whenever the queue has room.
  assign in_stall_o    = q_full_i;
  assign q_push_o      = in_valid_i && !q_full_i;
  assign q_item_o.mag  = mag;
  assign q_item_o.neg  = neg;

endmodule

/* design/sddf_queue.sv */
module sddf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sddf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sddf_pkg::item_t item_o
);
  import sddf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage holds payload only, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* design/sddf_back.sv */
module sddf_back #(
  parameter int unsigned Positions = sddf_pkg::PositionsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  sddf_pkg::item_t             q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sddf_pkg::PosW-1:0]   position_o,
  output logic [sddf_pkg::CodeW-1:0]  code_o,
  output logic                        last_o
);
  import sddf_pkg::*;

  localparam int unsigned      CntW    = $clog2(Positions);
  localparam logic [CntW-1:0]  PosLast = CntW'(Positions - 1);

  logic [CntW-1:0]   pos_q, pos_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [PosW-1:0]   position_q, position_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic              last_q, last_d;

  logic              first, active, step;
  logic [ValueW-1:0] cur_mag;
  logic              cur_neg;
  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic [ValueW-1:0] rem_full;
  logic [CodeW-1:0]  rem;

  // Position zero works straight from the head of the queue.
  assign first   = (pos_q == '0);
  assign active  = !first || q_valid_i;
  assign step    = active && (!out_valid_q || !out_stall_i);
  assign q_pop_o = step && first;
  assign cur_mag = first ? q_item_i.mag : mag_q;
  assign cur_neg = first ? q_item_i.neg : neg_q;

  // Peel off one decimal digit: quotient by reciprocal, remainder by shift and add.
  assign prod     = ProdW'(cur_mag) * ProdW'(RecipMul);
  assign quot     = prod[ProdW-1:RecipShift];
  assign rem_full = cur_mag - (ValueW'({quot, 3'b000}) + ValueW'({quot, 1'b0}));
  assign rem      = rem_full[CodeW-1:0];

  // Choose the code for this position and advance.
  always_comb begin
    pos_d       = pos_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    position_d  = position_q;
    code_d      = code_q;
    last_d      = last_q;
    if (step) begin
      out_valid_d = 1'b1;
      position_d  = PosW'(pos_q);
      last_d      = (pos_q == PosLast);
      pos_d       = (pos_q == PosLast) ? '0 : pos_q + 1'b1;
      mag_d       = ValueW'(quot);
      neg_d       = cur_neg;
      if (cur_mag != '0) begin
        code_d = rem;
      end else if (first) begin
        code_d = CodeZero;
      end else if (cur_neg) begin
        // The minus sign goes right above the top digit, once.
        code_d = CodeMinus;
        neg_d  = 1'b0;
      end else begin
        code_d = CodeBlank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    position_q <= position_d;
    code_q     <= code_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign code_o      = code_q;
  assign last_o      = last_q;

`ifndef NO_ASSERTIONS
  // The position counter never runs past the last display position.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosLast)
    else $error("position counter out of range");

  // A new word is only started from a filled queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  // The reciprocal division always leaves a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (cur_mag != '0) |-> (rem < CodeTen))
    else $error("remainder is not a decimal digit");

  // Once the digits run out mid-word, only a minus or a blank may follow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !first && (mag_q == '0) |=> (code_q == CodeMinus) || (code_q == CodeBlank))
    else $error("digit after the top digit");
`endif

endmodule

/* design/signed_decimal_digit_formatter_core.sv */
// Signed decimal formatter for a seven-segment display. Each accepted word on
// value_i yields exactly Positions result words, one per display position from
// position 0 (rightmost) upward: the decimal digits of the magnitude least
// significant first, a single 0 for zero, a minus code (10) right above the
// top digit of a negative value, and blank codes (11) in the rest; last_o
// marks the top position. Digits that do not fit are dropped from the top. The
// digit unit yields one digit per cycle, through a multiply-by-reciprocal divide
// by ten, while it has a word and the output is not stalled, and it starts a new
// word only after the top position of the last one. A two-word queue between the
// input and the digit unit takes new words while results are produced or stalled.
module signed_decimal_digit_formatter_core #(
  parameter int unsigned Positions = sddf_pkg::PositionsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sddf_pkg::ValueW-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sddf_pkg::PosW-1:0]   position_o,
  output logic [sddf_pkg::CodeW-1:0]  code_o,
  output logic                        last_o
);
  import sddf_pkg::*;

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_out;

  // Input side: sign and magnitude split.
  sddf_front u_front (
    .in_valid_i (in_valid_i),
    .value_i    (value_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  // Decoupling queue.
  sddf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  // Digit unit and output register.
  sddf_back #(
    .Positions (Positions)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .position_o  (position_o),
    .code_o      (code_o),
    .last_o      (last_o)
  );

endmodule
